@@ rtl/core/smm_pkg.sv @@
// Shared types, codes and helpers for the sensor to MIDI mapper.
// No dependencies; every module of the block imports this package.
package smm_pkg;

	// MIDI message command codes
	typedef enum logic [1:0] {
		CMD_NOTE_OFF    = 2'd0,
		CMD_NOTE_ON     = 2'd1,
		CMD_AFTERTOUCH  = 2'd2,
		CMD_CTRL_CHANGE = 2'd3
	} smm_cmd_t;

	// Mapping modes
	typedef enum logic [1:0] {
		MODE_KEY      = 2'd0,
		MODE_VELOCITY = 2'd1,
		MODE_CC_ABS   = 2'd2,
		MODE_CC_REL   = 2'd3
	} smm_mode_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_MODE        = 3'd0,
		REG_ROOT_NOTE   = 3'd1,
		REG_KEY_SETUP   = 3'd2,
		REG_VEL_THRESH  = 3'd3,
		REG_CTRL_NUMBER = 3'd4,
		REG_MIN_VALUE   = 3'd5,
		REG_MAX_VALUE   = 3'd6,
		REG_SPEED_STEP  = 3'd7
	} smm_reg_t;

	// Scale codes held in key_setup bits 2:1
	localparam logic [1:0] SCALE_MAJOR = 2'd1;
	localparam logic [1:0] SCALE_MINOR = 2'd2;

	// Key mode limits
	localparam logic [6:0] KEY_TOP_NOTE = 7'd119;
	// Velocity substituted for out-of-range samples
	localparam logic [6:0] VEL_OVERRANGE = 7'd65;
	// Relative controller bin edges
	localparam logic [6:0] BIN_EDGE_0 = 7'd26;
	localparam logic [6:0] BIN_EDGE_1 = 7'd51;
	localparam logic [6:0] BIN_EDGE_2 = 7'd77;
	localparam logic [6:0] BIN_EDGE_3 = 7'd102;

	// Configuration register set
	typedef struct packed {
		smm_mode_t  mode;
		logic [3:0] root_note;
		logic [2:0] key_setup;
		logic [6:0] velocity_threshold;
		logic [6:0] controller_number;
		logic [6:0] min_value;
		logic [6:0] max_value;
		logic [3:0] speed_step;
	} smm_cfg_t;

	// Remainder modulo 12 of a 7-bit value: reciprocal multiply by 171/2048,
	// exact over 0..127
	function automatic logic [3:0] mod12(input logic [6:0] x);
		logic [14:0] prod;
		logic [3:0]  quo;
		logic [6:0]  back;
		prod = x * 8'd171;
		quo  = prod[14:11];
		back = 7'(quo) * 7'd12;
		return 4'(x - back);
	endfunction

endpackage

@@ rtl/core/smm_key.sv @@
// Key mode note mapping: clamp, optional inversion and scale snapping.
// Depends on smm_pkg.
module smm_key (
	input  logic [7:0]      sample,
	input  smm_pkg::smm_cfg_t cfg,
	output logic [6:0]      note
);
	import smm_pkg::*;

	logic [6:0] clamped;
	logic [6:0] x;
	logic [3:0] root_eff;
	logic [3:0] shift;
	logic [4:0] pc_sum;
	logic [3:0] pc;
	logic       go_down;
	logic       go_up;

	// Clamp the sample into 0..119 and invert for a falling direction
	always_comb begin
		if (sample < 8'd3) begin
			clamped = 7'd0;
		end else if (sample > 8'd121) begin
			clamped = KEY_TOP_NOTE;
		end else begin
			clamped = 7'(sample - 8'd3);
		end
		x = cfg.key_setup[0] ? 7'(KEY_TOP_NOTE - clamped) : clamped;
	end

	// Pitch class relative to the root
	always_comb begin
		root_eff = (cfg.root_note > 4'd11) ? 4'd0 : cfg.root_note;
		shift    = 4'(4'd12 - root_eff);
		pc_sum   = {1'b0, mod12(x)} + {1'b0, shift};
		pc       = (pc_sum >= 5'd12) ? 4'(pc_sum - 5'd12) : pc_sum[3:0];
	end

	// Pick the snapping direction from the scale
	always_comb begin
		go_down = 1'b0;
		go_up   = 1'b0;
		if (cfg.key_setup[2:1] == SCALE_MAJOR) begin
			case (pc) inside
				4'd1:                     go_down = 1'b1;
				4'd3, 4'd6, 4'd8, 4'd10:  go_up   = 1'b1;
				default: ;
			endcase
		end else if (cfg.key_setup[2:1] == SCALE_MINOR) begin
			case (pc) inside
				4'd1, 4'd4, 4'd9, 4'd11:  go_down = 1'b1;
				4'd6:                     go_up   = 1'b1;
				default: ;
			endcase
		end
	end

	// Apply the snap; a note below zero saturates to zero
	always_comb begin
		if (go_down) begin
			note = (x == 7'd0) ? 7'd0 : 7'(x - 7'd1);
		end else if (go_up) begin
			note = 7'(x + 7'd1);
		end else begin
			note = x;
		end
	end

endmodule

@@ rtl/core/smm_cc.sv @@
// Controller value mapping for the absolute and relative controller modes.
// Depends on smm_pkg.
module smm_cc (
	input  logic [7:0]        sample,
	input  logic [6:0]        prev_value,
	input  smm_pkg::smm_cfg_t cfg,
	output logic [6:0]        value
);
	import smm_pkg::*;

	logic [6:0]        v;
	// absolute path
	logic signed [7:0] span;
	logic [6:0]        span_mag;
	logic              span_neg;
	logic              do_scale;
	logic [13:0]       prod;
	logic [7:0]        q0;
	logic [7:0]        rem;
	logic [7:0]        quo;
	logic signed [9:0] scaled;
	logic [6:0]        abs_value;
	// relative path
	logic [4:0]        step_mag;
	logic              step_neg;
	logic signed [8:0] sum;
	logic [6:0]        rel_value;

	// Saturate the sample to 127
	assign v = sample[7] ? 7'd127 : sample[6:0];

	// Absolute: scale into min..max, dividing by 127 with one correction
	always_comb begin
		span     = $signed({1'b0, cfg.max_value}) - $signed({1'b0, cfg.min_value});
		span_neg = span[7];
		span_mag = span_neg ? 7'(-span) : span[6:0];
		do_scale = (v > cfg.min_value) || ($signed({1'b0, v}) < span);
		prod     = v * span_mag;
		q0       = {1'b0, prod[13:7]};
		rem      = {1'b0, prod[6:0]} + q0;
		quo      = (rem >= 8'd127) ? 8'(q0 + 8'd1) : q0;
		if (span_neg) begin
			scaled = $signed({3'b0, cfg.min_value}) - $signed({2'b0, quo});
		end else begin
			scaled = $signed({3'b0, cfg.min_value}) + $signed({2'b0, quo});
		end
		if (!do_scale) begin
			abs_value = v;
		end else if (scaled < 0) begin
			abs_value = 7'd0;
		end else if (scaled > 10'sd127) begin
			abs_value = 7'd127;
		end else begin
			abs_value = scaled[6:0];
		end
	end

	// Relative: bin the sample into a signed step of zero, one or two speed units
	always_comb begin
		step_neg = 1'b0;
		if (v < BIN_EDGE_0) begin
			step_mag = {cfg.speed_step, 1'b0};
			step_neg = 1'b1;
		end else if (v < BIN_EDGE_1) begin
			step_mag = {1'b0, cfg.speed_step};
			step_neg = 1'b1;
		end else if (v < BIN_EDGE_2) begin
			step_mag = 5'd0;
		end else if (v < BIN_EDGE_3) begin
			step_mag = {1'b0, cfg.speed_step};
		end else begin
			step_mag = {cfg.speed_step, 1'b0};
		end
		if (step_neg) begin
			sum = $signed({2'b0, prev_value}) - $signed({4'b0, step_mag});
		end else begin
			sum = $signed({2'b0, prev_value}) + $signed({4'b0, step_mag});
		end
		// clamp to min..max; with min above max a sum above max gives max, else min
		if (sum <= $signed({2'b0, cfg.max_value}) && sum >= $signed({2'b0, cfg.min_value})) begin
			rel_value = sum[6:0];
		end else if (sum > $signed({2'b0, cfg.max_value})) begin
			rel_value = cfg.max_value;
		end else begin
			rel_value = cfg.min_value;
		end
	end

	assign value = (cfg.mode == MODE_CC_REL) ? rel_value : abs_value;

endmodule

@@ rtl/core/sensor_to_midi_mapper.sv @@
// Top level of the sensor to MIDI mapper: configuration registers, input
// register, message state and handshake. Depends on smm_pkg, smm_key, smm_cc.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  input   | in_valid / in_stall    | sample[7:0]
//  output  | out_valid / out_stall  | command[1:0], first_param[6:0],
//          |                        | second_param[6:0]
//  config  | cfg_we                 | cfg_index[2:0], cfg_data[6:0]
//
// One request per cycle while out_stall is low; a result passes through the
// input register and then the message state registers before it is valid.
// The message state registers are the output register; they update only when
// the output is free or being taken, so a stalled result holds.
// in_stall rises only while a result is held and the input register is full.
// Reset clears the message to note off, zero, and the registers to velocity
// mode with speed step one.
module sensor_to_midi_mapper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] sample,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] command,
	output logic [6:0] first_param,
	output logic [6:0] second_param,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [6:0] cfg_data
);
	import smm_pkg::*;

	smm_cfg_t   cfg_q;
	logic [7:0] sample_s1;
	logic       valid_s1;
	logic       out_valid_q;
	smm_cmd_t   cmd_q;
	logic [6:0] note_q;
	logic [6:0] pending_q;
	logic [6:0] value_q;
	logic [6:0] prev_q;

	logic       advance;
	logic       update;
	logic [6:0] key_note;
	logic [6:0] cc_value;
	logic [6:0] vel;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{mode: MODE_VELOCITY, root_note: 4'd0, key_setup: 3'd0,
				velocity_threshold: 7'd0, controller_number: 7'd0,
				min_value: 7'd0, max_value: 7'd0, speed_step: 4'd1};
		end else if (cfg_we) begin
			unique case (smm_reg_t'(cfg_index))
				REG_MODE:        cfg_q.mode               <= smm_mode_t'(cfg_data[1:0]);
				REG_ROOT_NOTE:   cfg_q.root_note          <= cfg_data[3:0];
				REG_KEY_SETUP:   cfg_q.key_setup          <= cfg_data[2:0];
				REG_VEL_THRESH:  cfg_q.velocity_threshold <= cfg_data;
				REG_CTRL_NUMBER: cfg_q.controller_number  <= cfg_data;
				REG_MIN_VALUE:   cfg_q.min_value          <= cfg_data;
				REG_MAX_VALUE:   cfg_q.max_value          <= cfg_data;
				REG_SPEED_STEP:  cfg_q.speed_step         <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Handshake: advance whenever the output slot is empty or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign update   = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			sample_s1 <= sample;
		end
	end

	smm_key u_key (
		.sample (sample_s1),
		.cfg    (cfg_q),
		.note   (key_note)
	);

	smm_cc u_cc (
		.sample     (sample_s1),
		.prev_value (prev_q),
		.cfg        (cfg_q),
		.value      (cc_value)
	);

	assign vel = sample_s1[7] ? VEL_OVERRANGE : sample_s1[6:0];

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// Message state: update from the held request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q     <= CMD_NOTE_OFF;
			note_q    <= 7'd0;
			pending_q <= 7'd0;
			value_q   <= 7'd0;
			prev_q    <= 7'd0;
		end else if (update) begin
			unique case (cfg_q.mode)
				MODE_KEY: begin
					// a new note forces note off, then commits when repeated
					if (note_q != key_note) begin
						if (key_note != pending_q) begin
							cmd_q     <= CMD_NOTE_OFF;
							pending_q <= key_note;
						end else begin
							note_q <= key_note;
						end
					end
				end
				MODE_VELOCITY: begin
					value_q <= vel;
					if (cmd_q == CMD_NOTE_OFF && vel > cfg_q.velocity_threshold) begin
						cmd_q <= CMD_NOTE_ON;
					end else if (cmd_q == CMD_NOTE_ON && vel > cfg_q.velocity_threshold) begin
						cmd_q <= CMD_AFTERTOUCH;
					end else if (cmd_q == CMD_NOTE_ON && vel < cfg_q.velocity_threshold) begin
						cmd_q <= CMD_NOTE_OFF;
					end
				end
				MODE_CC_ABS, MODE_CC_REL: begin
					cmd_q   <= CMD_CTRL_CHANGE;
					note_q  <= cfg_q.controller_number;
					value_q <= cc_value;
					prev_q  <= cc_value;
				end
				default: ;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign command      = cmd_q;
	assign first_param  = note_q;
	assign second_param = value_q;

`ifndef SYNTHESIS
	// input held back only while a result is waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall))
		else $error("input stalled with no result held");

	// controller modes always leave a control change
	a_cc_command: assert property (@(posedge clk) disable iff (!arst_n)
		(update && (cfg_q.mode == MODE_CC_ABS || cfg_q.mode == MODE_CC_REL))
		|=> (cmd_q == CMD_CTRL_CHANGE))
		else $error("controller update did not give control change");

	// relative value stays within a well-ordered range
	a_rel_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(update && cfg_q.mode == MODE_CC_REL && cfg_q.min_value <= cfg_q.max_value)
		|=> (value_q >= $past(cfg_q.min_value) && value_q <= $past(cfg_q.max_value)))
		else $error("relative controller value out of range");
`endif

endmodule

@@ tb/sv/tb_sensor_to_midi_mapper.sv @@
// Self-checking testbench for sensor_to_midi_mapper: directed and random sensor requests,
// results compared against an in-bench model of the MIDI message state.
// Depends on smm_pkg and the sensor_to_midi_mapper RTL.
`timescale 1ns / 100ps

module tb_sensor_to_midi_mapper;
	import smm_pkg::*;

	// key_setup fields not named in the package, and the random request count
	localparam logic       KEY_RISING      = 1'b0;
	localparam logic       KEY_FALLING     = 1'b1;
	localparam logic [1:0] SCALE_CHROMATIC = 2'd0;
	localparam logic [1:0] SCALE_UNUSED    = 2'd3;
	localparam int         RANDOM_REQUESTS = 950;

	typedef struct packed {
		smm_cmd_t   cmd;
		logic [6:0] num;
		logic [6:0] val;
	} midi_msg_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] sample;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] command;
	logic [6:0] first_param;
	logic [6:0] second_param;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [6:0] cfg_data;

	// model copy of registers and message state
	smm_cfg_t   reg_shadow;
	smm_cmd_t   msg_cmd;
	logic [6:0] msg_num;
	logic [6:0] held_note;
	logic [6:0] msg_val;
	logic [6:0] last_val;

	midi_msg_t expected_msgs[$];
	int        fail_count = 0;
	int        gap_pct    = 0;
	int        stall_pct  = 0;
	int        stall_left = 0;

	sensor_to_midi_mapper dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.command     (command),
		.first_param (first_param),
		.second_param(second_param),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int pick_gap();
		return ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
	endfunction

	// register value biased towards the ends of its range
	function automatic int pick_value(int lo, int hi);
		case ($urandom_range(6))
		0: return lo;
		1: return hi;
		default: return $urandom_range(lo, hi);
		endcase
	endfunction

	function automatic logic [6:0] clip7(int v);
		if (v < 0) return 7'd0;
		if (v > 127) return 7'd127;
		return 7'(v);
	endfunction

	// update the message from one sample and return what the block should send
	function automatic midi_msg_t map_sample(input logic [7:0] s);
		int         x, shift, y, v, thr, lo, span, bin, sum;
		logic [6:0] note;
		case (reg_shadow.mode)
		MODE_KEY: begin
			if (s > 8'd2 && s < 8'd122) x = int'(s) - 3;
			else x = (s < 8'd3) ? 0 : int'(KEY_TOP_NOTE);
			if (reg_shadow.key_setup[0] == KEY_FALLING) x = int'(KEY_TOP_NOTE) - x;
			// roots above b fall back to c
			shift = (reg_shadow.root_note > 4'd11) ? 12 : 12 - int'(reg_shadow.root_note);
			y = x + shift;
			// snap pitch classes outside the scale, counted from the root
			case (reg_shadow.key_setup[2:1])
			SCALE_MAJOR:
				case (y % 12)
				1: y = y - 1;
				3, 6, 8, 10: y = y + 1;
				default: ;
				endcase
			SCALE_MINOR:
				case (y % 12)
				1, 4, 9, 11: y = y - 1;
				6: y = y + 1;
				default: ;
				endcase
			default: ;
			endcase
			note = clip7(y - shift);
			// a new note silences first and is taken on the next equal sample
			if (msg_num != note) begin
				if (note != held_note) begin
					msg_cmd   = CMD_NOTE_OFF;
					held_note = note;
				end else begin
					msg_num = note;
				end
			end
		end
		MODE_VELOCITY: begin
			v = (s > 8'd127) ? int'(VEL_OVERRANGE) : int'(s);
			thr = int'(reg_shadow.velocity_threshold);
			msg_val = 7'(v);
			if (msg_cmd == CMD_NOTE_OFF && v > thr) msg_cmd = CMD_NOTE_ON;
			else if (msg_cmd == CMD_NOTE_ON && v > thr) msg_cmd = CMD_AFTERTOUCH;
			else if (msg_cmd == CMD_NOTE_ON && v < thr) msg_cmd = CMD_NOTE_OFF;
		end
		MODE_CC_ABS: begin
			v = (s > 8'd127) ? 127 : int'(s);
			lo = int'(reg_shadow.min_value);
			span = int'(reg_shadow.max_value) - lo;
			if (v > lo || v < span) v = v * span / 127 + lo;
			msg_cmd  = CMD_CTRL_CHANGE;
			msg_num  = reg_shadow.controller_number;
			msg_val  = clip7(v);
			last_val = msg_val;
		end
		default: begin
			v = (s > 8'd127) ? 127 : int'(s);
			if (v < int'(BIN_EDGE_0)) bin = -2;
			else if (v < int'(BIN_EDGE_1)) bin = -1;
			else if (v < int'(BIN_EDGE_2)) bin = 0;
			else if (v < int'(BIN_EDGE_3)) bin = 1;
			else bin = 2;
			sum = int'(last_val) + bin * int'(reg_shadow.speed_step);
			msg_cmd = CMD_CTRL_CHANGE;
			msg_num = reg_shadow.controller_number;
			if (sum <= int'(reg_shadow.max_value) && sum >= int'(reg_shadow.min_value))
				msg_val = clip7(sum);
			else if (sum > int'(reg_shadow.max_value))
				msg_val = reg_shadow.max_value;
			else
				msg_val = reg_shadow.min_value;
			last_val = msg_val;
		end
		endcase
		return '{cmd: msg_cmd, num: msg_num, val: msg_val};
	endfunction

	// send one sample request, hold it until taken, then maybe idle
	task automatic send_sample(input logic [7:0] s);
		int n;
		@(negedge clk);
		in_valid <= 1'b1;
		sample   <= s;
		do @(posedge clk); while (in_stall);
		expected_msgs.push_back(map_sample(s));
		if ($urandom_range(99) < gap_pct) begin
			n = pick_gap();
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// drop valid and hold off until every result has been taken
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_msgs.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// write one register; bits above its width may carry junk
	task automatic write_reg(input smm_reg_t idx, input int value, input int width,
			input bit junk);
		logic [6:0] keep, data;
		keep = 7'((1 << width) - 1);
		data = 7'(value) & keep;
		if (junk && $urandom_range(3) == 0) data = data | (7'($urandom) & ~keep);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
		REG_MODE:        reg_shadow.mode = smm_mode_t'(data[1:0]);
		REG_ROOT_NOTE:   reg_shadow.root_note = data[3:0];
		REG_KEY_SETUP:   reg_shadow.key_setup = data[2:0];
		REG_VEL_THRESH:  reg_shadow.velocity_threshold = data;
		REG_CTRL_NUMBER: reg_shadow.controller_number = data;
		REG_MIN_VALUE:   reg_shadow.min_value = data;
		REG_MAX_VALUE:   reg_shadow.max_value = data;
		default:         reg_shadow.speed_step = data[3:0];
		endcase
	endtask

	// drain, then load the whole register set
	task automatic setup(input int mode, input int root, input int keyset, input int thr,
			input int ccnum, input int lo_val, input int hi_val, input int speed,
			input bit junk);
		wait_drained();
		write_reg(REG_MODE, mode, 2, junk);
		write_reg(REG_ROOT_NOTE, root, 4, junk);
		write_reg(REG_KEY_SETUP, keyset, 3, junk);
		write_reg(REG_VEL_THRESH, thr, 7, junk);
		write_reg(REG_CTRL_NUMBER, ccnum, 7, junk);
		write_reg(REG_MIN_VALUE, lo_val, 7, junk);
		write_reg(REG_MAX_VALUE, hi_val, 7, junk);
		write_reg(REG_SPEED_STEP, speed, 4, junk);
	endtask

	// clamping ends, inversion, scale snapping, odd roots and note commit
	task automatic test_key_mode();
		gap_pct   = 0;
		stall_pct = 0;
		setup(MODE_KEY, 0, {SCALE_CHROMATIC, KEY_RISING}, 0, 0, 0, 0, 1, 1'b0);
		send_sample(8'd0);
		send_sample(8'd255);
		send_sample(8'd255);
		send_sample(8'd121);
		send_sample(8'd2);
		// root b in major pulls the lowest note below zero
		setup(MODE_KEY, 11, {SCALE_MAJOR, KEY_RISING}, 0, 0, 0, 0, 1, 1'b0);
		send_sample(8'd0);
		send_sample(8'd3);
		send_sample(8'd50);
		send_sample(8'd50);
		setup(MODE_KEY, 12, {SCALE_UNUSED, KEY_FALLING}, 0, 0, 0, 0, 1, 1'b0);
		send_sample(8'd122);
		send_sample(8'd40);
		setup(MODE_KEY, 5, {SCALE_MINOR, KEY_FALLING}, 0, 0, 0, 0, 1, 1'b0);
		send_sample(8'd200);
		send_sample(8'd60);
		send_sample(8'd60);
	endtask

	// threshold crossings, equal level, over-range samples and aftertouch
	task automatic test_velocity_mode();
		gap_pct   = 30;
		stall_pct = 30;
		setup(MODE_VELOCITY, 0, 0, 64, 0, 0, 0, 1, 1'b0);
		send_sample(8'd64);
		send_sample(8'd100);
		send_sample(8'd64);
		send_sample(8'd10);
		send_sample(8'd255);
		send_sample(8'd100);
	endtask

	// full range, over-range sample, and a range with min above max
	task automatic test_abs_controller();
		setup(MODE_CC_ABS, 0, 0, 0, 127, 0, 127, 1, 1'b0);
		send_sample(8'd0);
		send_sample(8'd255);
		setup(MODE_CC_ABS, 0, 0, 0, 0, 100, 20, 1, 1'b0);
		send_sample(8'd50);
		send_sample(8'd120);
	endtask

	// largest steps to both limits, zero speed and an inverted range
	task automatic test_rel_controller();
		setup(MODE_CC_REL, 0, 0, 0, 64, 0, 127, 15, 1'b0);
		send_sample(8'd255);
		send_sample(8'd0);
		send_sample(8'd90);
		setup(MODE_CC_REL, 0, 0, 0, 1, 90, 10, 0, 1'b0);
		send_sample(8'd60);
	endtask

	// random register sets, each followed by a burst shaped for its mode
	task automatic test_random_traffic();
		int         sent, n, burst, run, thr;
		smm_mode_t  m;
		logic [7:0] s;
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			m = smm_mode_t'($urandom_range(3));
			setup(m, pick_value(0, 15), pick_value(0, 7), pick_value(0, 127),
				pick_value(0, 127), pick_value(0, 127), pick_value(0, 127),
				pick_value(0, 15), 1'b1);
			case ($urandom_range(2))
			0: gap_pct = 0;
			1: gap_pct = 10;
			default: gap_pct = 40;
			endcase
			case ($urandom_range(2))
			0: stall_pct = 0;
			1: stall_pct = 10;
			default: stall_pct = 40;
			endcase
			burst = $urandom_range(15, 60);
			n = 0;
			while (n < burst) begin
				run = 1;
				case (m)
				MODE_KEY: begin
					// repeat samples so that pending notes get committed
					s = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 130));
					run = $urandom_range(1, 3);
				end
				MODE_VELOCITY: begin
					thr = int'(reg_shadow.velocity_threshold);
					if ($urandom_range(9) < 6)
						s = 8'($urandom_range(thr < 3 ? 0 : thr - 3, thr + 3));
					else
						s = 8'($urandom);
				end
				default:
					s = ($urandom_range(9) < 7) ? 8'($urandom_range(0, 127)) : 8'($urandom);
				endcase
				repeat (run) send_sample(s);
				n = n + run;
				if ($urandom_range(49) == 0) wait_drained();
			end
			sent = sent + n;
		end
	endtask

	// random output stall, mostly short
	always @(negedge clk) begin
		if (stall_left > 0) stall_left--;
		else if (stall_pct != 0 && $urandom_range(99) < stall_pct) stall_left = pick_gap();
		out_stall <= (stall_left > 0);
	end

	// compare every taken result with the oldest expectation
	always @(posedge clk) begin
		midi_msg_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_msgs.size() == 0) begin
				$error("result with no request pending: command %0d first_param %0d second_param %0d",
					command, first_param, second_param);
				fail_count++;
			end else begin
				want = expected_msgs.pop_front();
				if (command !== want.cmd) begin
					$error("command: expected %0d, got %0d", want.cmd, command);
					fail_count++;
				end
				if (first_param !== want.num) begin
					$error("first_param: expected %0d, got %0d", want.num, first_param);
					fail_count++;
				end
				if (second_param !== want.val) begin
					$error("second_param: expected %0d, got %0d", want.val, second_param);
					fail_count++;
				end
			end
		end
	end

	// hard stop on a hung run
	initial begin
		#2000000;
		$display("sensor_to_midi_mapper: mismatch");
		$finish;
	end

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		sample    = 8'd0;
		out_stall = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_MODE;
		cfg_data  = 7'd0;
		// reset state of registers and message
		reg_shadow = '{mode: MODE_VELOCITY, root_note: 4'd0, key_setup: 3'd0,
			velocity_threshold: 7'd0, controller_number: 7'd0, min_value: 7'd0,
			max_value: 7'd0, speed_step: 4'd1};
		msg_cmd   = CMD_NOTE_OFF;
		msg_num   = 7'd0;
		held_note = 7'd0;
		msg_val   = 7'd0;
		last_val  = 7'd0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_key_mode();
		test_velocity_mode();
		test_abs_controller();
		test_rel_controller();
		test_random_traffic();

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("sensor_to_midi_mapper: match");
		else
			$display("sensor_to_midi_mapper: mismatch");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/smm_pkg.sv
rtl/core/smm_key.sv
rtl/core/smm_cc.sv
rtl/core/sensor_to_midi_mapper.sv
tb/sv/tb_sensor_to_midi_mapper.sv
